[src/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tcw_pkg;

	// Field widths fixed by the item format
	localparam int CHAR_W     = 8;
	localparam int COL_PORT_W = 7;
	localparam int ROW_PORT_W = 5;

	// Default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Character codes and fixed values
	localparam logic [CHAR_W-1:0] BLANK_CHAR  = 8'd32;
	localparam logic [CHAR_W-1:0] FIXED_ATTR  = 8'd7;
	localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;
	localparam logic [CHAR_W-1:0] CH_FORMFEED = 8'd12;
	localparam logic [CHAR_W-1:0] NO_CHAR     = 8'd0;

	// Tab stops every 2**TAB_SHIFT columns
	localparam int TAB_SHIFT = 3;

	// Item function codes
	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_DRAIN,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;    // take the input item
		logic exec;       // apply the captured item to cursor and store
		logic sweep;      // one step of a walk over the whole store
		logic sweep_copy; // walk copies rows up instead of blanking
		logic out_load;   // load the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sweep_last;  // current walk step is the last cell
		logic need_scroll; // captured item runs past the bottom row
		logic need_clear;  // captured item is a form feed
		logic out_free;    // output register can take a result now
	} stat_t;

endpackage

`default_nettype wire

[src/tcw_ctrl.sv]
// Controller state machine for the text console writer.
// Depends on tcw_pkg; drives tcw_datapath through cmd_t and reads stat_t.
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (stat.sweep_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				priority if (stat.need_clear) state_d = ST_CLEAR;
				else if (stat.need_scroll) state_d = ST_SCROLL;
				else if (stat.out_free) state_d = ST_IDLE;
				else state_d = ST_DONE;
			end
			ST_SCROLL, ST_CLEAR: begin
				if (stat.sweep_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.exec     = 1'b1;
				cmd.out_load = !stat.need_clear && !stat.need_scroll && stat.out_free;
			end
			ST_SCROLL: begin
				cmd.sweep      = 1'b1;
				cmd.sweep_copy = 1'b1;
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
			end
			ST_DONE: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded while output register is held");

	a_capture_leads_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.exec)
		else $error("captured item not executed in the next cycle");

	a_sweep_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !cmd.capture && !cmd.exec && !cmd.out_load)
		else $error("store walk overlaps other work");
`endif

endmodule

`default_nettype wire

[src/tcw_datapath.sv]
// Datapath of the text console writer: character store, cursor, walk
// counter and output register. Depends on tcw_pkg; commanded by tcw_ctrl.
`default_nettype none

module tcw_datapath import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output stat_t                      stat,
	input  wire logic                  func,
	input  wire logic [CHAR_W-1:0]     ch,
	input  wire logic [COL_PORT_W-1:0] read_col,
	input  wire logic [ROW_PORT_W-1:0] read_row,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [CHAR_W-1:0]          cell_char,
	output logic [CHAR_W-1:0]          cell_attr,
	output logic [COL_PORT_W-1:0]      cursor_col,
	output logic [ROW_PORT_W-1:0]      cursor_row,
	output logic                       scrolled,
	output logic                       cleared
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int XW     = COL_W + 1;

	localparam logic [XW-1:0]     COLS_X    = XW'(COLUMNS);
	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);

	function automatic logic in_screen(logic [COL_PORT_W-1:0] c, logic [ROW_PORT_W-1:0] r);
		in_screen = (int'(c) < COLUMNS) && (int'(r) < ROWS);
	endfunction

	// Captured item
	logic                  func_q;
	logic [CHAR_W-1:0]     ch_q;
	logic [COL_PORT_W-1:0] rcol_q;
	logic [ROW_PORT_W-1:0] rrow_q;

	// Cursor and per-item flags
	logic [COL_W-1:0] cur_x_q, cur_x_d, x_n;
	logic [ROW_W-1:0] cur_y_q, cur_y_d, y_n;
	logic             scr_q, scr_d, scr_n;
	logic             clr_q, clr_d;

	// Store and its ports
	logic [CHAR_W-1:0] screen_mem_q [CELLS];
	logic [CHAR_W-1:0] rdata_q;
	logic              rd_en, wr_en;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [CHAR_W-1:0] wr_data;

	// Store walk: counter plus one write stage behind the read
	logic [ADDR_W-1:0] sweep_q;
	logic              wr_vld_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              wr_mem_s1;
	logic              copy_rd;

	// Output register
	logic              out_vld_q;
	logic [CHAR_W-1:0] cell_q;
	logic [COL_W-1:0]  ocol_q;
	logic [ROW_W-1:0]  orow_q;
	logic              oscr_q, oclr_q;

	// Item decode
	logic             is_tab, is_nl, is_ff, is_prt, wrap, nl, put_wr;
	logic [XW-1:0]    xe, adv_x;
	logic [CHAR_W-1:0] cell_d;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			ch_q   <= ch;
			rcol_q <= read_col;
			rrow_q <= read_row;
		end
	end

	always_comb begin
		is_tab = (ch_q == CH_TAB);
		is_nl  = (ch_q == CH_NEWLINE);
		is_ff  = (ch_q == CH_FORMFEED);
		is_prt = !is_tab && !is_nl && !is_ff;
		xe     = {1'b0, cur_x_q};
		adv_x  = is_tab ? (((xe >> TAB_SHIFT) + XW'(1)) << TAB_SHIFT) : (xe + XW'(1));
		wrap   = !is_nl && !is_ff && (adv_x >= COLS_X);
		nl     = is_nl || wrap;

		x_n   = cur_x_q;
		y_n   = cur_y_q;
		scr_n = 1'b0;
		if (func_q == FUNC_PUT) begin
			priority if (is_ff) begin
				x_n = '0;
				y_n = '0;
			end else if (nl) begin
				x_n = '0;
				if (cur_y_q == LAST_ROW) begin
					scr_n = 1'b1;
				end else begin
					y_n = cur_y_q + ROW_W'(1);
				end
			end else begin
				x_n = adv_x[COL_W-1:0];
			end
		end

		cur_x_d = cmd.exec ? x_n : cur_x_q;
		cur_y_d = cmd.exec ? y_n : cur_y_q;
		scr_d   = cmd.exec ? scr_n : scr_q;
		clr_d   = cmd.exec ? (func_q == FUNC_PUT && is_ff) : clr_q;
		put_wr  = cmd.exec && (func_q == FUNC_PUT) && is_prt;

		if (func_q == FUNC_READ) begin
			cell_d = in_screen(rcol_q, rrow_q) ? rdata_q : BLANK_CHAR;
		end else begin
			cell_d = NO_CHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			scr_q   <= 1'b0;
			clr_q   <= 1'b0;
		end else begin
			cur_x_q <= cur_x_d;
			cur_y_q <= cur_y_d;
			scr_q   <= cmd.capture ? 1'b0 : scr_d;
			clr_q   <= cmd.capture ? 1'b0 : clr_d;
		end
	end

	// Store port selection
	always_comb begin
		copy_rd = cmd.sweep && cmd.sweep_copy && (sweep_q < COPY_END);
		rd_en   = (cmd.capture && func == FUNC_READ) || copy_rd;
		if (copy_rd) begin
			rd_addr = sweep_q + COLS_A;
		end else if (in_screen(read_col, read_row)) begin
			rd_addr = ADDR_W'(read_row) * COLS_A + ADDR_W'(read_col);
		end else begin
			rd_addr = '0;
		end

		wr_en = wr_vld_s1 || put_wr;
		if (wr_vld_s1) begin
			wr_addr = wr_addr_s1;
			wr_data = wr_mem_s1 ? rdata_q : BLANK_CHAR;
		end else begin
			wr_addr = ADDR_W'(cur_y_q) * COLS_A + ADDR_W'(cur_x_q);
			wr_data = ch_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) screen_mem_q[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= screen_mem_q[rd_addr];
	end

	// Walk counter and delayed write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q   <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			wr_vld_s1 <= cmd.sweep;
			if (cmd.sweep) begin
				sweep_q <= (sweep_q == LAST_CELL) ? '0 : sweep_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			wr_addr_s1 <= sweep_q;
			wr_mem_s1  <= copy_rd;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_q <= cell_d;
			ocol_q <= cur_x_d;
			orow_q <= cur_y_d;
			oscr_q <= scr_d;
			oclr_q <= clr_d;
		end
	end

	assign stat.sweep_last  = (sweep_q == LAST_CELL);
	assign stat.need_scroll = scr_n;
	assign stat.need_clear  = (func_q == FUNC_PUT) && is_ff;
	assign stat.out_free    = !out_vld_q || !out_stall;

	assign out_valid  = out_vld_q;
	assign cell_char  = cell_q;
	assign cell_attr  = FIXED_ATTR;
	assign cursor_col = COL_PORT_W'(ocol_q);
	assign cursor_row = ROW_PORT_W'(orow_q);
	assign scrolled   = oscr_q;
	assign cleared    = oclr_q;

`ifndef SYNTHESIS
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(put_wr && wr_vld_s1))
		else $error("put write collides with store walk write");

	a_capture_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !wr_vld_s1)
		else $error("item read issued before the store walk finished writing");

	a_cursor_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cur_x_q) < COLUMNS)
		else $error("cursor column past the last column");

	a_cursor_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cur_y_q) < ROWS)
		else $error("cursor row past the last row");
`endif

endmodule

`default_nettype wire

[src/text_console_writer.sv]
// Text console writer: top level joining the controller and the datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// A COLUMNS x ROWS character console with a cursor. A put item (func 0)
// stores ch at the cursor and advances it; tab jumps to the next multiple
// of 8, newline goes to column 0 of the next row, form feed blanks the
// screen and homes the cursor. Running off the last column starts a new
// line, running off the last row scrolls the screen up one row and blanks
// the bottom row. A read item (func 1) returns the character of one cell
// (a blank outside the screen); the attribute is always 7. Every item gives
// exactly one result, carrying the cursor after the item and the scrolled
// and cleared flags. Ordinary puts, tabs, newlines and reads are accepted,
// then executed into the output register. The store has one read and one
// write port, so a scroll or a clear walks it one cell per cycle. After
// reset the block blanks the store the same way and keeps in_stall high
// until that walk and its last write are done. A finished result waits in
// the output register while the next item is accepted.
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  func,
	input  wire logic [CHAR_W-1:0]     ch,
	input  wire logic [COL_PORT_W-1:0] read_col,
	input  wire logic [ROW_PORT_W-1:0] read_row,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [CHAR_W-1:0]          cell_char,
	output logic [CHAR_W-1:0]          cell_attr,
	output logic [COL_PORT_W-1:0]      cursor_col,
	output logic [ROW_PORT_W-1:0]      cursor_row,
	output logic                       scrolled,
	output logic                       cleared
);

	cmd_t  cmd;
	stat_t stat;

	// Sequence each transfer: capture, execute, optional store walk, deliver
	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold the store, the cursor and the result register
	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.func       (func),
		.ch         (ch),
		.read_col   (read_col),
		.read_row   (read_row),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_char  (cell_char),
		.cell_attr  (cell_attr),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.scrolled   (scrolled),
		.cleared    (cleared)
	);

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer (80x25 text console with cursor).
// Depends on tcw_pkg and the text_console_writer RTL; no other files or arguments.

module tb_top;
	import tcw_pkg::*;

	// Screen geometry under test: the package defaults
	localparam int SCR_COLS  = COLUMNS_DEF;
	localparam int SCR_ROWS  = ROWS_DEF;
	localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;
	localparam int TAB_WIDTH = 1 << TAB_SHIFT;

	// A scroll or a clear walks the store one cell per cycle; settle for one more walk
	localparam int SETTLE_CYCLES = SCR_CELLS + 64;
	// Slowest legal run: every transfer a full store walk plus the longest idling,
	// taken several times over
	localparam int CYCLE_LIMIT = 16_000_000;
	localparam int PHASE_ITEMS = 567;
	localparam int PRINT_CAP   = 40;

	// One input transfer
	typedef struct packed {
		logic                  fn;
		logic [CHAR_W-1:0]     chr;
		logic [COL_PORT_W-1:0] col;
		logic [ROW_PORT_W-1:0] row;
	} console_item_t;

	// One result transfer
	typedef struct packed {
		logic [CHAR_W-1:0]     glyph;
		logic [CHAR_W-1:0]     attr;
		logic [COL_PORT_W-1:0] col;
		logic [ROW_PORT_W-1:0] row;
		logic                  scrolled;
		logic                  cleared;
	} console_result_t;

	// Directed stimulus row; the result is typed in only where it is plain to see
	typedef struct packed {
		console_item_t   item;
		logic [7:0]      reps;
		logic            typed;
		console_result_t want;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  func = FUNC_PUT;
	logic [CHAR_W-1:0]     ch = '0;
	logic [COL_PORT_W-1:0] read_col = '0;
	logic [ROW_PORT_W-1:0] read_row = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [CHAR_W-1:0]     cell_char;
	logic [CHAR_W-1:0]     cell_attr;
	logic [COL_PORT_W-1:0] cursor_col;
	logic [ROW_PORT_W-1:0] cursor_row;
	logic                  scrolled;
	logic                  cleared;

	// Shadow copy of the console: store, cursor
	logic [CHAR_W-1:0] shadow_screen [SCR_CELLS];
	int                shadow_col;
	int                shadow_row;

	// Results owed by the block, oldest first
	console_result_t screen_replies [$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int items_sent     = 0;
	int send_idle_pct  = 29;
	int recv_idle_pct  = 64;

	// Reset and extremes first, then each put kind, then the tab wrap and a clear.
	directed_row_t directed_rows [17] = '{
		'{'{FUNC_READ, 8'd0, 7'd0, 5'd0}, 8'd1, 1'b1,
			'{BLANK_CHAR, FIXED_ATTR, 7'd0, 5'd0, 1'b0, 1'b0}},
		'{'{FUNC_READ, 8'd0, 7'd79, 5'd24}, 8'd1, 1'b1,
			'{BLANK_CHAR, FIXED_ATTR, 7'd0, 5'd0, 1'b0, 1'b0}},
		'{'{FUNC_READ, 8'd0, 7'd127, 5'd31}, 8'd1, 1'b1,
			'{BLANK_CHAR, FIXED_ATTR, 7'd0, 5'd0, 1'b0, 1'b0}},
		'{'{FUNC_READ, 8'd0, 7'd80, 5'd0}, 8'd1, 1'b1,
			'{BLANK_CHAR, FIXED_ATTR, 7'd0, 5'd0, 1'b0, 1'b0}},
		'{'{FUNC_READ, 8'd0, 7'd0, 5'd25}, 8'd1, 1'b1,
			'{BLANK_CHAR, FIXED_ATTR, 7'd0, 5'd0, 1'b0, 1'b0}},
		'{'{FUNC_PUT, 8'd65, 7'd0, 5'd0}, 8'd1, 1'b1,
			'{NO_CHAR, FIXED_ATTR, 7'd1, 5'd0, 1'b0, 1'b0}},
		'{'{FUNC_PUT, 8'd0, 7'd0, 5'd0}, 8'd1, 1'b0, '0},
		'{'{FUNC_PUT, 8'd255, 7'd0, 5'd0}, 8'd1, 1'b0, '0},
		'{'{FUNC_PUT, 8'd13, 7'd0, 5'd0}, 8'd1, 1'b0, '0},
		'{'{FUNC_PUT, CH_TAB, 7'd0, 5'd0}, 8'd1, 1'b0, '0},
		'{'{FUNC_PUT, CH_NEWLINE, 7'd0, 5'd0}, 8'd1, 1'b0, '0},
		'{'{FUNC_READ, 8'd0, 7'd0, 5'd0}, 8'd1, 1'b0, '0},
		'{'{FUNC_READ, 8'd0, 7'd3, 5'd0}, 8'd1, 1'b0, '0},
		// ten tabs from column 0: the last one runs off the right edge
		'{'{FUNC_PUT, CH_TAB, 7'd0, 5'd0}, 8'd10, 1'b0, '0},
		'{'{FUNC_PUT, CH_FORMFEED, 7'd0, 5'd0}, 8'd1, 1'b1,
			'{NO_CHAR, FIXED_ATTR, 7'd0, 5'd0, 1'b0, 1'b1}},
		'{'{FUNC_READ, 8'd0, 7'd0, 5'd0}, 8'd1, 1'b1,
			'{BLANK_CHAR, FIXED_ATTR, 7'd0, 5'd0, 1'b0, 1'b0}},
		'{'{FUNC_READ, 8'd0, 7'd2, 5'd0}, 8'd1, 1'b1,
			'{BLANK_CHAR, FIXED_ATTR, 7'd0, 5'd0, 1'b0, 1'b0}}
	};

	text_console_writer #(
		.COLUMNS(SCR_COLS),
		.ROWS   (SCR_ROWS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.ch        (ch),
		.read_col  (read_col),
		.read_row  (read_row),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cell_char (cell_char),
		.cell_attr (cell_attr),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.scrolled  (scrolled),
		.cleared   (cleared)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Shadow console
	// ---------------------------------------------------------------

	function automatic void blank_shadow();
		int i;
		for (i = 0; i < SCR_CELLS; i++)
			shadow_screen[i] = BLANK_CHAR;
		shadow_col = 0;
		shadow_row = 0;
	endfunction

	// Move to column 0 of the next row; past the bottom, shift every row up one
	// and blank the last. Return whether the screen scrolled.
	function automatic logic advance_line();
		int i;
		shadow_col = 0;
		shadow_row++;
		if (shadow_row < SCR_ROWS)
			return 1'b0;
		for (i = 0; i < SCR_CELLS - SCR_COLS; i++)
			shadow_screen[i] = shadow_screen[i + SCR_COLS];
		for (i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++)
			shadow_screen[i] = BLANK_CHAR;
		shadow_row = SCR_ROWS - 1;
		return 1'b1;
	endfunction

	// Apply one accepted transfer to the shadow console and return what the
	// block must answer.
	function automatic console_result_t emulate_console(console_item_t it);
		console_result_t r;
		r.glyph    = NO_CHAR;
		r.attr     = FIXED_ATTR;
		r.scrolled = 1'b0;
		r.cleared  = 1'b0;
		if (it.fn == FUNC_READ) begin
			// off-screen reads return a blank and touch nothing
			if (int'(it.col) < SCR_COLS && int'(it.row) < SCR_ROWS)
				r.glyph = shadow_screen[int'(it.row) * SCR_COLS + int'(it.col)];
			else
				r.glyph = BLANK_CHAR;
		end else if (it.chr == CH_TAB) begin
			shadow_col += TAB_WIDTH - (shadow_col % TAB_WIDTH);
			if (shadow_col >= SCR_COLS)
				r.scrolled = advance_line();
		end else if (it.chr == CH_NEWLINE) begin
			r.scrolled = advance_line();
		end else if (it.chr == CH_FORMFEED) begin
			blank_shadow();
			r.cleared = 1'b1;
		end else begin
			// every other byte, control bytes included, lands in the store
			shadow_screen[shadow_row * SCR_COLS + shadow_col] = it.chr;
			shadow_col++;
			if (shadow_col >= SCR_COLS)
				r.scrolled = advance_line();
		end
		r.col = COL_PORT_W'(shadow_col);
		r.row = ROW_PORT_W'(shadow_row);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(string what, int got, int want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
	endtask

	task automatic check_reply();
		console_result_t want;
		if (screen_replies.size() == 0) begin
			report_mismatch("result with nothing outstanding", int'(cell_char), 0);
		end else begin
			want = screen_replies.pop_front();
			if (cell_char !== want.glyph)
				report_mismatch("cell_char", int'(cell_char), int'(want.glyph));
			if (cell_attr !== want.attr)
				report_mismatch("cell_attr", int'(cell_attr), int'(want.attr));
			if (cursor_col !== want.col)
				report_mismatch("cursor_col", int'(cursor_col), int'(want.col));
			if (cursor_row !== want.row)
				report_mismatch("cursor_row", int'(cursor_row), int'(want.row));
			if (scrolled !== want.scrolled)
				report_mismatch("scrolled", int'(scrolled), int'(want.scrolled));
			if (cleared !== want.cleared)
				report_mismatch("cleared", int'(cleared), int'(want.cleared));
		end
	endtask

	// Result side: stall at random, take a transfer whenever valid meets no stall.
	// Values read here are the ones from before the edge.
	always @(posedge clk) begin
		cycle_count++;
		out_stall <= ($urandom_range(99) < recv_idle_pct);
		if (arst_n && out_valid && !out_stall)
			check_reply();
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Idle at random, then offer one transfer and hold it until it is taken.
	// On return the transfer has just been accepted and in_valid is still high,
	// so the next call may keep it high without lowering it in the same step.
	task automatic send_item(console_item_t it, logic typed, console_result_t want);
		console_result_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= it.fn;
		ch       <= it.chr;
		read_col <= it.col;
		read_row <= it.row;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = emulate_console(it);
		screen_replies.push_back(typed ? want : pred);
		items_sent++;
	endtask

	// Read transfer; mostly on screen, sometimes anywhere the ports reach
	function automatic console_item_t read_item();
		console_item_t it;
		it.fn  = FUNC_READ;
		it.chr = CHAR_W'($urandom_range(255));
		if ($urandom_range(99) < 85) begin
			it.col = COL_PORT_W'($urandom_range(SCR_COLS - 1));
			it.row = ROW_PORT_W'($urandom_range(SCR_ROWS - 1));
		end else begin
			it.col = COL_PORT_W'($urandom_range(127));
			it.row = ROW_PORT_W'($urandom_range(31));
		end
		return it;
	endfunction

	// Put transfer; the read coordinates carry junk that the block must ignore
	function automatic console_item_t put_item(logic [CHAR_W-1:0] b);
		console_item_t it;
		it.fn  = FUNC_PUT;
		it.chr = b;
		it.col = COL_PORT_W'($urandom_range(127));
		it.row = ROW_PORT_W'($urandom_range(31));
		return it;
	endfunction

	// Hold off until every owed result has come back
	task automatic drain_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (screen_replies.size() != 0)
			@(posedge clk);
	endtask

	// Write text and tabs until the cursor runs off the right edge, with reads
	// mixed in. Ends on a printable at the last column or a tab past it.
	task automatic fill_line();
		int                pick;
		logic              wrapped;
		logic [CHAR_W-1:0] b;
		wrapped = 1'b0;
		while (!wrapped) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				send_item(read_item(), 1'b0, '0);
			end else begin
				if (pick < 30) begin
					b = CH_TAB;
				end else begin
					do
						b = CHAR_W'($urandom_range(255));
					while (b == CH_TAB || b == CH_NEWLINE || b == CH_FORMFEED);
				end
				send_item(put_item(b), 1'b0, '0);
				wrapped = (shadow_col == 0);
			end
		end
	endtask

	initial begin
		int r;
		int phase;
		int pick;
		int n;
		blank_shadow();
		// hold reset from the start, then release it for good
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the block holds in_stall through its start-up blanking
		for (r = 0; r < $size(directed_rows); r++)
			repeat (directed_rows[r].reps)
				send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
		drain_replies();

		// Random part in three idling phases: sender light / receiver heavy,
		// then the reverse, then no idling at all
		items_sent = 0;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 29;
					recv_idle_pct = 64;
				end
				1: begin
					send_idle_pct = 64;
					recv_idle_pct = 29;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			while (items_sent < (phase + 1) * PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 30) begin
					fill_line();
				end else if (pick < 40) begin
					// newlines drive the cursor to the bottom and scroll
					n = $urandom_range(6, 1);
					repeat (n) send_item(put_item(CH_NEWLINE), 1'b0, '0);
				end else if (pick < 80) begin
					n = $urandom_range(8, 1);
					repeat (n) send_item(read_item(), 1'b0, '0);
				end else if (pick < 96) begin
					// noise: any byte at all
					send_item(put_item(CHAR_W'($urandom_range(255))), 1'b0, '0);
				end else if (pick < 98) begin
					send_item(put_item(CH_FORMFEED), 1'b0, '0);
				end else begin
					drain_replies();
				end
			end
			drain_replies();
		end

		// Let a stray result show up if the block has one left
		in_valid <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (screen_replies.size() != 0)
			report_mismatch("results never delivered", 0, screen_replies.size());

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
